/* hdl/hover_thrust_integral_controller_assert.svh */
// Assertion shorthands for the hover thrust controller checks.
`ifndef HOVER_THRUST_INTEGRAL_CONTROLLER_ASSERT_SVH
`define HOVER_THRUST_INTEGRAL_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define HTIC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("htic check failed");

// Next-cycle implication, disabled while reset is high.
`define HTIC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("htic check failed");

`endif

/* hdl/htic_pkg.sv */
`timescale 1ns / 1ps
package htic_pkg;

   localparam int PULSE_MIN_DEF = 1000;
   localparam int PULSE_MAX_DEF = 2000;
   localparam int TIME_MAX_DEF  = 86399;

   localparam int HOVER_COUNT   = 20;
   localparam int VOLT_COUNT    = 20;
   localparam int LOSS_COUNT    = 100;
   localparam int HOVER_ERR_MIN = 10;
   localparam int LOSS_ERR_MIN  = 25;
   localparam int CELL_LOW_MV   = 3500;
   localparam int LOSS_BACKDATE = 8;

   localparam int MATCH_W = 5;
   localparam int VOLT_W  = 5;
   localparam int LOSS_W  = 7;
   localparam int TIME_W  = 17;
   localparam int PULSE_W = 12;
   localparam int OUT_PULSE_W = 11;

   typedef enum logic [1:0] {
      REG_TARGET = 2'd0,
      REG_CELLS  = 2'd1,
      REG_KP     = 2'd2,
      REG_KI     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      THR_START = 2'd0,
      THR_OFF   = 2'd1,
      THR_LAW   = 2'd2
   } thr_kind_type;

   typedef struct packed {
      logic                opcode;
      logic [15:0]         thrust_g;
      logic [15:0]         voltage_mv;
      logic [TIME_W-1:0]   time_s;
      logic                abort;
   } sample_type;

   typedef struct packed {
      thr_kind_type        kind;
      logic [15:0]         err;
      logic [31:0]         integral;
      logic                hovering;
      logic                low_battery;
      logic                finished;
      logic                set_hover;
      logic                clear_hover;
      logic [TIME_W-1:0]   safe_time_s;
      logic [TIME_W-1:0]   whole_time_s;
   } track_type;

endpackage

/* hdl/hover_thrust_integral_controller.sv */
`timescale 1ns / 1ps
// Hover thrust PI controller. Each request transfer carries a start command
// (tuser low) or a thrust sample (tuser high) and yields exactly one response
// transfer with the servo pulse, the hover, low battery and finished flags,
// the pulse recorded at hover and the two elapsed times. The block takes one
// item per clock cycle while the response side accepts (rsp_tready). A result
// passes the input register, run tracking, gain products and the clamp into
// the response register. The run state (integral, counters, flags, times)
// is updated in the tracking stage as an item leaves it, which sets the
// one-item-per-cycle rate. The user must write gains and target on the csr
// channel while no item is in flight (not enforced); csr_ready is always high.
module hover_thrust_integral_controller
   import htic_pkg::*;
#(
   parameter int PULSE_MIN = PULSE_MIN_DEF,
   parameter int PULSE_MAX = PULSE_MAX_DEF,
   parameter int TIME_MAX  = TIME_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // thrust_g, voltage_mv, time_s, abort, zero pad
   input  logic        req_tuser,   // opcode

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // throttle_us, hovering, low_battery, finished, hover_throttle_us,
   // safe_time_s, whole_time_s, zero pad
   output logic [63:0] rsp_tdata,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [14:0]  target_ff;
   logic [3:0]   cells_ff;
   logic [15:0]  kp_ff;
   logic [15:0]  ki_ff;

   logic         v1_ff, v1_in;
   logic         v2_ff, v2_in;
   logic         v3_ff, v3_in;
   logic         rsp_valid_ff, rsp_valid_in;
   sample_type   smp_ff;
   track_type    trk2_ff;
   track_type    trk3_ff;
   logic [63:0]  rsp_data_ff, rsp_data_in;
   logic [OUT_PULSE_W-1:0] hover_pulse_ff, hover_pulse_in;

   sample_type   smp_in;
   track_type    trk;
   logic [PULSE_W-1:0] pulse;
   logic [OUT_PULSE_W-1:0] throttle;
   logic         req_fire;
   logic         adv1, adv2, adv3;
   logic         fire1, fire2, fire3;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         cells_ff  <= 4'd2;
         kp_ff     <= '0;
         ki_ff     <= 16'd410;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            REG_TARGET: target_ff <= csr_data[14:0];
            REG_CELLS:  cells_ff  <= csr_data[3:0];
            REG_KP:     kp_ff     <= csr_data;
            REG_KI:     ki_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   assign adv3 = !rsp_valid_ff || rsp_tready;
   assign adv2 = !v3_ff || adv3;
   assign adv1 = !v2_ff || adv2;
   assign req_tready = !v1_ff || adv1;

   assign req_fire = req_tvalid && req_tready;
   assign fire1 = v1_ff && adv1;
   assign fire2 = v2_ff && adv2;
   assign fire3 = v3_ff && adv3;

   always_comb begin
      smp_in.opcode     = req_tuser;
      smp_in.thrust_g   = req_tdata[15:0];
      smp_in.voltage_mv = req_tdata[31:16];
      smp_in.time_s     = req_tdata[48:32];
      smp_in.abort      = req_tdata[49];

      v1_in        = req_fire ? 1'b1 : (fire1 ? 1'b0 : v1_ff);
      v2_in        = fire1 ? 1'b1 : (fire2 ? 1'b0 : v2_ff);
      v3_in        = fire2 ? 1'b1 : (fire3 ? 1'b0 : v3_ff);
      rsp_valid_in = fire3 ? 1'b1 : ((rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff);
   end

   htic_track #(
      .TIME_MAX(TIME_MAX)
   ) u_track (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire1),
      .smp             (smp_ff),
      .target_weight_g (target_ff),
      .cell_count      (cells_ff),
      .trk             (trk)
   );

   htic_pi #(
      .PULSE_MIN(PULSE_MIN),
      .PULSE_MAX(PULSE_MAX)
   ) u_pi (
      .clock    (clock),
      .fire     (fire2),
      .err      (trk2_ff.err),
      .integral (trk2_ff.integral),
      .kp_q12   (kp_ff),
      .ki_q12   (ki_ff),
      .pulse    (pulse)
   );

   always_comb begin
      case (trk3_ff.kind)
         THR_START: throttle = OUT_PULSE_W'(PULSE_MIN);
         THR_LAW:   throttle = pulse[OUT_PULSE_W-1:0];
         THR_OFF:   throttle = '0;
         default:   throttle = '0;
      endcase

      if (trk3_ff.clear_hover) begin
         hover_pulse_in = '0;
      end else if (trk3_ff.set_hover) begin
         hover_pulse_in = pulse[OUT_PULSE_W-1:0];
      end else begin
         hover_pulse_in = hover_pulse_ff;
      end

      rsp_data_in = {5'd0,
                     trk3_ff.whole_time_s,
                     trk3_ff.safe_time_s,
                     hover_pulse_in,
                     trk3_ff.finished,
                     trk3_ff.low_battery,
                     trk3_ff.hovering,
                     throttle};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         hover_pulse_ff <= '0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire3) begin
            hover_pulse_ff <= hover_pulse_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         smp_ff <= smp_in;
      end
      if (fire1) begin
         trk2_ff <= trk;
      end
      if (fire2) begin
         trk3_ff <= trk2_ff;
      end
      if (fire3) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* hdl/htic_track.sv */
`timescale 1ns / 1ps
module htic_track
   import htic_pkg::*;
#(
   parameter int TIME_MAX = TIME_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  sample_type  smp,
   input  logic [14:0] target_weight_g,
   input  logic [3:0]  cell_count,
   output track_type   trk
);

   logic signed [31:0]  integral_ff, integral_in;
   logic                hover_ff, hover_in;
   logic                low_ff, low_in;
   logic                done_ff, done_in;
   logic                loss_seen_ff, loss_seen_in;
   logic [MATCH_W-1:0]  match_ff, match_in;
   logic [VOLT_W-1:0]   volt_cnt_ff, volt_cnt_in;
   logic [LOSS_W-1:0]   loss_cnt_ff, loss_cnt_in;
   logic [TIME_W-1:0]   start_time_ff, start_time_in;
   logic [TIME_W-1:0]   low_time_ff, low_time_in;
   logic [TIME_W-1:0]   loss_time_ff, loss_time_in;

   logic [TIME_W-1:0]   now;
   logic [TIME_W-1:0]   backdated;
   logic signed [17:0]  err_wide;
   logic signed [15:0]  err_sat;
   logic signed [32:0]  isum;
   logic signed [31:0]  isum_sat;
   logic [16:0]         mag;
   logic [20:0]         mag_x20;
   logic [20:0]         mag_x10;
   logic [16:0]         volt_limit;
   logic                hover_match;
   logic                loss_hit;
   logic                volt_low;

   function automatic logic [TIME_W-1:0] elapsed(input logic [TIME_W-1:0] e,
                                                input logic [TIME_W-1:0] s);
      logic [TIME_W:0] d;
      if (e > s) begin
         d = {1'b0, e} - {1'b0, s};
      end else begin
         d = {1'b0, e} + (TIME_W+1)'(TIME_MAX) - {1'b0, s};
      end
      return d[TIME_W-1:0];
   endfunction

   always_comb begin
      now = (smp.time_s > TIME_W'(TIME_MAX)) ? TIME_W'(TIME_MAX) : smp.time_s;
      if (now >= TIME_W'(LOSS_BACKDATE)) begin
         backdated = now - TIME_W'(LOSS_BACKDATE);
      end else begin
         backdated = TIME_W'({1'b0, now} + (TIME_W+1)'(TIME_MAX + 1 - LOSS_BACKDATE));
      end

      err_wide = $signed({3'b000, target_weight_g})
                 - $signed({{2{smp.thrust_g[15]}}, smp.thrust_g});
      if (err_wide > 18'sd32767) begin
         err_sat = 16'sh7FFF;
      end else if (err_wide < -18'sd32768) begin
         err_sat = -16'sd32768;
      end else begin
         err_sat = err_wide[15:0];
      end

      isum = {integral_ff[31], integral_ff} + 33'(err_sat);
      if (isum[32] != isum[31]) begin
         isum_sat = isum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         isum_sat = isum[31:0];
      end

      mag = err_sat[15] ? (17'd0 - {err_sat[15], err_sat}) : {1'b0, err_sat};
      mag_x20 = {4'b0000, mag} * 21'd20;
      mag_x10 = {4'b0000, mag} * 21'd10;
      volt_limit = 17'(CELL_LOW_MV) * {13'd0, cell_count};

      hover_match = (mag <= 17'(HOVER_ERR_MIN)) || (mag_x20 <= {6'd0, target_weight_g});
      loss_hit    = (mag > 17'(LOSS_ERR_MIN)) && (mag_x10 > {6'd0, target_weight_g});
      volt_low    = {1'b0, smp.voltage_mv} <= volt_limit;

      integral_in   = integral_ff;
      hover_in      = hover_ff;
      low_in        = low_ff;
      done_in       = done_ff;
      loss_seen_in  = loss_seen_ff;
      match_in      = match_ff;
      volt_cnt_in   = volt_cnt_ff;
      loss_cnt_in   = loss_cnt_ff;
      start_time_in = start_time_ff;
      low_time_in   = low_time_ff;
      loss_time_in  = loss_time_ff;

      trk.kind        = THR_OFF;
      trk.set_hover   = 1'b0;
      trk.clear_hover = 1'b0;

      if (!smp.opcode) begin
         integral_in   = '0;
         hover_in      = 1'b0;
         low_in        = 1'b0;
         done_in       = 1'b0;
         loss_seen_in  = 1'b0;
         match_in      = '0;
         volt_cnt_in   = '0;
         loss_cnt_in   = '0;
         start_time_in = '0;
         low_time_in   = '0;
         loss_time_in  = '0;
         trk.kind        = THR_START;
         trk.clear_hover = 1'b1;
      end else if (done_ff) begin
         trk.kind = THR_OFF;
      end else if (smp.abort) begin
         done_in  = 1'b1;
         trk.kind = THR_OFF;
      end else begin
         integral_in = isum_sat;
         trk.kind    = THR_LAW;
         if (!hover_ff) begin
            if (hover_match) begin
               if (match_ff == MATCH_W'(HOVER_COUNT - 1)) begin
                  match_in      = '0;
                  start_time_in = now;
                  hover_in      = 1'b1;
                  trk.set_hover = 1'b1;
               end else begin
                  match_in = match_ff + 1'b1;
               end
            end else begin
               match_in = '0;
            end
         end else begin
            if (!low_ff) begin
               if (volt_low) begin
                  if (volt_cnt_ff == VOLT_W'(VOLT_COUNT - 1)) begin
                     volt_cnt_in = '0;
                     low_time_in = now;
                     low_in      = 1'b1;
                  end else begin
                     volt_cnt_in = volt_cnt_ff + 1'b1;
                  end
               end else begin
                  volt_cnt_in = '0;
               end
            end
            if (loss_hit) begin
               if (loss_cnt_ff == LOSS_W'(LOSS_COUNT - 1)) begin
                  loss_cnt_in  = '0;
                  loss_time_in = backdated;
                  loss_seen_in = 1'b1;
                  done_in      = 1'b1;
                  trk.kind     = THR_OFF;
               end else begin
                  loss_cnt_in = loss_cnt_ff + 1'b1;
               end
            end else begin
               loss_cnt_in = '0;
            end
         end
      end

      trk.err          = err_sat;
      trk.integral     = isum_sat;
      trk.hovering     = hover_in;
      trk.low_battery  = low_in;
      trk.finished     = done_in;
      trk.safe_time_s  = low_in ? elapsed(low_time_in, start_time_in) : '0;
      trk.whole_time_s = loss_seen_in ? elapsed(loss_time_in, start_time_in) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff   <= '0;
         hover_ff      <= 1'b0;
         low_ff        <= 1'b0;
         done_ff       <= 1'b0;
         loss_seen_ff  <= 1'b0;
         match_ff      <= '0;
         volt_cnt_ff   <= '0;
         loss_cnt_ff   <= '0;
         start_time_ff <= '0;
         low_time_ff   <= '0;
         loss_time_ff  <= '0;
      end else if (fire) begin
         integral_ff   <= integral_in;
         hover_ff      <= hover_in;
         low_ff        <= low_in;
         done_ff       <= done_in;
         loss_seen_ff  <= loss_seen_in;
         match_ff      <= match_in;
         volt_cnt_ff   <= volt_cnt_in;
         loss_cnt_ff   <= loss_cnt_in;
         start_time_ff <= start_time_in;
         low_time_ff   <= low_time_in;
         loss_time_ff  <= loss_time_in;
      end
   end

endmodule

/* hdl/htic_pi.sv */
`timescale 1ns / 1ps
module htic_pi
   import htic_pkg::*;
#(
   parameter int PULSE_MIN = PULSE_MIN_DEF,
   parameter int PULSE_MAX = PULSE_MAX_DEF
) (
   input  logic               clock,
   input  logic               fire,
   input  logic [15:0]        err,
   input  logic [31:0]        integral,
   input  logic [15:0]        kp_q12,
   input  logic [15:0]        ki_q12,
   output logic [PULSE_W-1:0] pulse
);

   localparam int SPAN = PULSE_MAX - PULSE_MIN;

   logic signed [32:0] prod_kp_ff, prod_kp_in;
   logic signed [48:0] prod_ki_ff, prod_ki_in;
   logic signed [49:0] sum;
   logic signed [49:0] biased;
   logic signed [37:0] quot;

   always_comb begin
      prod_kp_in = 33'($signed({1'b0, kp_q12})) * 33'($signed(err));
      prod_ki_in = 49'($signed({1'b0, ki_q12})) * 49'($signed(integral));
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         prod_kp_ff <= prod_kp_in;
         prod_ki_ff <= prod_ki_in;
      end
   end

   // truncate toward zero: bias negative sums before the arithmetic shift
   always_comb begin
      sum    = 50'(prod_kp_ff) + 50'(prod_ki_ff);
      biased = sum + (sum[49] ? 50'sd4095 : 50'sd0);
      quot   = 38'(biased >>> 12);
      if (quot < 38'sd0) begin
         pulse = PULSE_W'(PULSE_MIN);
      end else if (quot > 38'(SPAN)) begin
         pulse = PULSE_W'(PULSE_MAX);
      end else begin
         pulse = PULSE_W'(PULSE_MIN) + quot[PULSE_W-1:0];
      end
   end

endmodule

/* hdl/htic_checker.sv */
`timescale 1ns / 1ps
`include "hover_thrust_integral_controller_assert.svh"
module htic_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // hold a stalled response
   `HTIC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // no response straight out of reset
   `HTIC_ASSERT_NOW(a_rsp_after_reset, clock, reset, $past(reset), !rsp_tvalid)

   // finished run drives the pulse to zero
   `HTIC_ASSERT_NOW(a_off_when_done, clock, reset, rsp_tvalid && rsp_tdata[13], rsp_tdata[10:0] == 11'd0)

   // battery and loss reports and the hover pulse need hover first
   `HTIC_ASSERT_NOW(a_hover_first, clock, reset, rsp_tvalid && !rsp_tdata[11], !rsp_tdata[12] && (rsp_tdata[24:14] == 11'd0) && (rsp_tdata[58:42] == 17'd0))

endmodule

bind hover_thrust_integral_controller htic_checker u_htic_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* sim/tb_hover_thrust_integral_controller.sv */
`timescale 1ns / 1ps
module tb_hover_thrust_integral_controller;
   import htic_pkg::*;

   localparam bit OP_START  = 1'b0;
   localparam bit OP_SAMPLE = 1'b1;
   localparam longint INT32_TOP    = 64'sh7FFFFFFF;
   localparam longint INT32_BOTTOM = -64'sh80000000;

   typedef struct {
      logic [10:0] throttle_us;
      logic        hovering;
      logic        low_battery;
      logic        finished;
      logic [10:0] hover_throttle_us;
      logic [16:0] safe_time_s;
      logic [16:0] whole_time_s;
   } thrust_report_t;

   class thrust_scoreboard;
      bit [14:0] target;
      bit [3:0]  cells;
      bit [15:0] kp;
      bit [15:0] ki;

      int        integral;
      bit [10:0] throttle;
      bit        hover;
      bit        low_batt;
      bit        done;
      bit        loss_seen;
      int        match_cnt;
      int        volt_cnt;
      int        loss_cnt;
      bit [10:0] hover_pulse;
      int        start_t;
      int        low_batt_t;
      int        loss_t;

      thrust_report_t due_reports[$];
      int report_errors;

      function new();
         target = 0;
         cells = 2;
         kp = 0;
         ki = 410;
         report_errors = 0;
         clear_run();
      endfunction

      function void clear_run();
         integral = 0;
         throttle = 0;
         hover = 0;
         low_batt = 0;
         done = 0;
         loss_seen = 0;
         match_cnt = 0;
         volt_cnt = 0;
         loss_cnt = 0;
         hover_pulse = 0;
         start_t = 0;
         low_batt_t = 0;
         loss_t = 0;
      endfunction

      function void set_reg(csr_index_type idx, bit [15:0] val);
         case (idx)
            REG_TARGET: target = val[14:0];
            REG_CELLS:  cells = val[3:0];
            REG_KP:     kp = val;
            REG_KI:     ki = val;
         endcase
      endfunction

      function int span(int e, int s);
         return (e > s) ? e - s : e + TIME_MAX_DEF - s;
      endfunction

      function void note_sample(bit op, shortint thrust, bit [15:0] volt, bit [16:0] t,
                                bit ab);
         int now;
         int err;
         int mag;
         longint acc;
         thrust_report_t r;
         now = (t > TIME_MAX_DEF) ? TIME_MAX_DEF : int'(t);
         if (op == OP_START) begin
            clear_run();
            throttle = PULSE_MIN_DEF;
         end else if (!done) begin
            if (ab) begin
               done = 1;
               throttle = 0;
            end else begin
               err = int'(target) - int'(thrust);
               if (err > 32767) err = 32767;
               if (err < -32768) err = -32768;
               acc = longint'(integral) + err;
               if (acc > INT32_TOP) acc = INT32_TOP;
               if (acc < INT32_BOTTOM) acc = INT32_BOTTOM;
               integral = int'(acc);
               acc = longint'(kp) * err + longint'(ki) * integral;
               acc = PULSE_MIN_DEF + acc / 4096;
               if (acc > PULSE_MAX_DEF) acc = PULSE_MAX_DEF;
               if (acc < PULSE_MIN_DEF) acc = PULSE_MIN_DEF;
               throttle = acc[10:0];
               mag = (err < 0) ? -err : err;
               if (!hover) begin
                  if (mag <= HOVER_ERR_MIN || mag * 20 <= int'(target)) begin
                     match_cnt++;
                     if (match_cnt >= HOVER_COUNT) begin
                        match_cnt = 0;
                        hover_pulse = throttle;
                        start_t = now;
                        hover = 1;
                     end
                  end else begin
                     match_cnt = 0;
                  end
               end else begin
                  if (!low_batt) begin
                     if (int'(volt) <= CELL_LOW_MV * int'(cells)) begin
                        volt_cnt++;
                        if (volt_cnt >= VOLT_COUNT) begin
                           volt_cnt = 0;
                           low_batt_t = now;
                           low_batt = 1;
                        end
                     end else begin
                        volt_cnt = 0;
                     end
                  end
                  if (mag > LOSS_ERR_MIN && mag * 10 > int'(target)) begin
                     loss_cnt++;
                     if (loss_cnt >= LOSS_COUNT) begin
                        loss_cnt = 0;
                        loss_t = (now + TIME_MAX_DEF + 1 - LOSS_BACKDATE) % (TIME_MAX_DEF + 1);
                        loss_seen = 1;
                        done = 1;
                        throttle = 0;
                     end
                  end else begin
                     loss_cnt = 0;
                  end
               end
            end
         end
         r.throttle_us = done ? 11'd0 : throttle;
         r.hovering = hover;
         r.low_battery = low_batt;
         r.finished = done;
         r.hover_throttle_us = hover_pulse;
         r.safe_time_s = low_batt ? span(low_batt_t, start_t) : 0;
         r.whole_time_s = loss_seen ? span(loss_t, start_t) : 0;
         due_reports.push_back(r);
      endfunction

      function void check_report(logic [63:0] d);
         thrust_report_t want;
         thrust_report_t got;
         got.throttle_us = d[10:0];
         got.hovering = d[11];
         got.low_battery = d[12];
         got.finished = d[13];
         got.hover_throttle_us = d[24:14];
         got.safe_time_s = d[41:25];
         got.whole_time_s = d[58:42];
         if (due_reports.size() == 0) begin
            report_errors++;
            if (report_errors <= 10) $display("unexpected response transfer %h", d);
            return;
         end
         want = due_reports.pop_front();
         if (want.throttle_us !== got.throttle_us || want.hovering !== got.hovering ||
             want.low_battery !== got.low_battery || want.finished !== got.finished ||
             want.hover_throttle_us !== got.hover_throttle_us ||
             want.safe_time_s !== got.safe_time_s || want.whole_time_s !== got.whole_time_s)
         begin
            report_errors++;
            if (report_errors <= 10)
               $display({"mismatch (exp/act): throttle %0d/%0d hover %b/%b low %b/%b ",
                         "fin %b/%b hover_thr %0d/%0d safe %0d/%0d whole %0d/%0d"},
                        want.throttle_us, got.throttle_us, want.hovering, got.hovering,
                        want.low_battery, got.low_battery, want.finished, got.finished,
                        want.hover_throttle_us, got.hover_throttle_us,
                        want.safe_time_s, got.safe_time_s,
                        want.whole_time_s, got.whole_time_s);
         end
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [55:0]   req_tdata = '0;
   logic          req_tuser = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [63:0]   rsp_tdata;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = REG_TARGET;
   logic [15:0]   csr_data = '0;

   thrust_scoreboard chk = new();
   int  items_sent = 0;
   int  rtc = 0;
   int  time_mode = 1;
   bit  quiet = 0;
   bit  stall_toggle = 0;

   hover_thrust_integral_controller DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic bit [16:0] next_time();
      bit [16:0] t;
      if ($urandom_range(0, 49) == 0) return $urandom_range(TIME_MAX_DEF + 1, 131071);
      t = rtc;
      case (time_mode)
         0: ;
         2: rtc += $urandom_range(0, 3);
         default: rtc += 1;
      endcase
      if (rtc > TIME_MAX_DEF) rtc -= TIME_MAX_DEF + 1;
      return t;
   endfunction

   function automatic shortint close_thrust();
      int tol;
      int th;
      tol = int'(chk.target) / 20;
      if (tol < HOVER_ERR_MIN) tol = HOVER_ERR_MIN;
      th = int'(chk.target) + tol - int'($urandom_range(0, 2 * tol));
      if (th > 32767) th = 32767;
      return shortint'(th);
   endfunction

   function automatic shortint lost_thrust();
      int m;
      int th;
      m = int'(chk.target) / 10 + 1;
      if (m <= LOSS_ERR_MIN) m = LOSS_ERR_MIN + 1;
      m += int'($urandom_range(0, 300));
      th = int'(chk.target) - m;
      if (int'(chk.target) + m <= 32767 && $urandom_range(0, 3) == 0) th = int'(chk.target) + m;
      return shortint'(th);
   endfunction

   function automatic bit [15:0] low_volt();
      return $urandom_range(0, CELL_LOW_MV * int'(chk.cells));
   endfunction

   function automatic bit [15:0] high_volt();
      return $urandom_range(CELL_LOW_MV * int'(chk.cells) + 1, 65535);
   endfunction

   task automatic push_item(bit op, shortint thrust, bit [15:0] volt, bit [16:0] t, bit ab);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {6'd0, ab, t, volt, thrust};
      do @(posedge clock); while (!req_tready);
      chk.note_sample(op, thrust, volt, t, ab);
      items_sent++;
      if (!quiet && $urandom_range(0, 99) < 11) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (chk.due_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic program_regs(bit [15:0] tgt, bit [15:0] cells, bit [15:0] kp,
                               bit [15:0] ki);
      bit [15:0] vals [4];
      vals = '{tgt, cells, kp, ki};
      wait_idle();
      foreach (vals[i]) begin
         csr_valid <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_data <= vals[i];
         do @(posedge clock); while (!csr_ready);
         chk.set_reg(csr_index_type'(i), vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic pick_settings();
      bit [15:0] tgt;
      bit [15:0] cells;
      bit [15:0] kp;
      bit [15:0] ki;
      case ($urandom_range(0, 3))
         0: tgt = $urandom;
         1: tgt = $urandom_range(0, 1) ? 16'h7FFF : 16'h0000;
         2: tgt = $urandom_range(100, 3000);
         default: tgt = $urandom_range(0, 32767);
      endcase
      case ($urandom_range(0, 4))
         0: cells = $urandom_range(0, 1);
         1: cells = 2;
         2: cells = 12;
         3: cells = 16'h000F | ($urandom & 16'hFFF0);
         default: cells = $urandom_range(2, 12);
      endcase
      case ($urandom_range(0, 3))
         0: kp = 0;
         1: kp = 16'hFFFF;
         2: kp = $urandom_range(0, 8192);
         default: kp = $urandom;
      endcase
      case ($urandom_range(0, 3))
         0: ki = 0;
         1: ki = 16'hFFFF;
         2: ki = $urandom_range(0, 1024);
         default: ki = $urandom;
      endcase
      program_regs(tgt, cells, kp, ki);
   endtask

   task automatic stir_noise();
      int n;
      n = $urandom_range(10, 25);
      repeat (n)
         push_item($urandom_range(0, 9) != 0, $urandom, $urandom, $urandom_range(0, 131071),
                   $urandom_range(0, 9) == 0);
   endtask

   task automatic fly_run();
      int n;
      int streak;
      int end_kind;
      bit sync_low;
      time_mode = $urandom_range(0, 3);
      rtc = (time_mode == 3) ? TIME_MAX_DEF - $urandom_range(0, 30)
                             : $urandom_range(0, TIME_MAX_DEF);
      push_item(OP_START, $urandom, $urandom, $urandom, $urandom_range(0, 1));
      n = $urandom_range(20, 26);
      for (int i = 0; i < n; i++)
         push_item(OP_SAMPLE, ($urandom_range(0, 29) == 0) ? lost_thrust() : close_thrust(),
                   $urandom, next_time(), 1'b0);
      end_kind = $urandom_range(0, 2);
      sync_low = (end_kind == 0) && ($urandom_range(0, 2) == 0);
      n = $urandom_range(0, 30);
      for (int i = 0; i < n; i++)
         push_item(OP_SAMPLE, close_thrust(),
                   (!sync_low && $urandom_range(0, 9) != 0) ? low_volt() : high_volt(),
                   next_time(), 1'b0);
      case (end_kind)
         0: begin
            // break one loss streak before the real one
            if (!sync_low && $urandom_range(0, 2) == 0) begin
               n = $urandom_range(10, 80);
               repeat (n) push_item(OP_SAMPLE, lost_thrust(), $urandom, next_time(), 1'b0);
               push_item(OP_SAMPLE, close_thrust(), $urandom, next_time(), 1'b0);
            end
            streak = sync_low ? LOSS_COUNT : LOSS_COUNT + $urandom_range(0, 3);
            for (int i = 0; i < streak; i++)
               push_item(OP_SAMPLE, lost_thrust(),
                         (sync_low ? (i >= streak - VOLT_COUNT) : $urandom_range(0, 1))
                            ? low_volt() : high_volt(),
                         next_time(), 1'b0);
         end
         1: push_item(OP_SAMPLE, $urandom, $urandom, next_time(), 1'b1);
         default: begin
            n = $urandom_range(10, 30);
            repeat (n)
               push_item(OP_SAMPLE, $urandom, $urandom, next_time(),
                         $urandom_range(0, 29) == 0);
         end
      endcase
      n = $urandom_range(0, 3);
      repeat (n)
         push_item(OP_SAMPLE, $urandom, $urandom, next_time(), $urandom_range(0, 1));
   endtask

   initial begin : response_side
      bit stall_seen;
      int stall_left;
      stall_seen = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) chk.check_report(rsp_tdata);
         if (stall_toggle != stall_seen) begin
            stall_seen = stall_toggle;
            stall_left = 200;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet || ($urandom_range(0, 99) >= 11);
         end
      end
   end

   initial begin : stimulus
      int base;
      int flights;
      int wait_cycles;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      push_item(OP_SAMPLE, 100, 0, 0, 1'b0);
      push_item(OP_SAMPLE, -32768, 16'hFFFF, 17'h1FFFF, 1'b0);
      push_item(OP_SAMPLE, 32767, 3999, TIME_MAX_DEF, 1'b0);
      push_item(OP_SAMPLE, 0, 7000, 10, 1'b1);
      push_item(OP_SAMPLE, 5, 7000, 11, 1'b0);
      push_item(OP_SAMPLE, 5, 7000, 12, 1'b1);
      push_item(OP_START, -1, 16'hFFFF, 17'h1FFFF, 1'b1);
      push_item(OP_SAMPLE, 0, 7000, 5, 1'b0);
      program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_item(OP_START, 0, 0, 0, 1'b0);
      push_item(OP_SAMPLE, -32768, 0, 100, 1'b0);
      push_item(OP_SAMPLE, 32767, 0, 101, 1'b0);
      push_item(OP_SAMPLE, 0, 52500, 102, 1'b0);
      push_item(OP_SAMPLE, -32768, 52501, 103, 1'b1);
      program_regs(0, 0, 0, 0);
      push_item(OP_START, 0, 0, 0, 1'b0);
      push_item(OP_SAMPLE, 0, 0, 0, 1'b0);
      push_item(OP_SAMPLE, 26, 1, TIME_MAX_DEF, 1'b0);
      push_item(OP_SAMPLE, -10, 0, 0, 1'b0);
      push_item(OP_SAMPLE, 11, 0, 0, 1'b0);
      program_regs(1000, 1, 4096, 4096);
      push_item(OP_START, 0, 0, 0, 1'b0);
      push_item(OP_SAMPLE, 950, 3500, 7, 1'b0);
      push_item(OP_SAMPLE, 1050, 3501, 8, 1'b0);
      push_item(OP_SAMPLE, 1000, 0, 9, 1'b0);

      base = items_sent;
      flights = 0;
      while (items_sent < base + 500) begin
         if (flights % 2 == 0) pick_settings();
         quiet = (flights == 2 || flights == 3);
         // hold the response side off while the request side keeps pushing
         if (flights == 0) stall_toggle = ~stall_toggle;
         if ($urandom_range(0, 4) == 0) stir_noise();
         else fly_run();
         flights++;
      end
      quiet = 0;

      // drive the integral into both saturation limits
      time_mode = 1;
      program_regs(16'h7FFF, 2, $urandom, $urandom);
      push_item(OP_START, 0, 0, 0, 1'b0);
      for (int i = 0; i < 65545; i++)
         push_item(OP_SAMPLE, shortint'(-$urandom_range(0, 32768)), $urandom, next_time(),
                   1'b0);
      repeat (3) push_item(OP_SAMPLE, 32767, $urandom, next_time(), 1'b0);
      program_regs(0, 2, $urandom, $urandom);
      push_item(OP_START, 0, 0, 0, 1'b0);
      for (int i = 0; i < 65545; i++)
         push_item(OP_SAMPLE, 32767, $urandom, next_time(), 1'b0);
      repeat (3) push_item(OP_SAMPLE, -32768, $urandom, next_time(), 1'b0);

      req_tvalid <= 1'b0;
      wait_cycles = 0;
      while (chk.due_reports.size() != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (10) @(posedge clock);
      if (chk.report_errors == 0 && chk.due_reports.size() == 0) begin
         $display("tb_hover_thrust_integral_controller: PASS");
      end else begin
         if (chk.due_reports.size() != 0)
            $display("%0d responses never arrived", chk.due_reports.size());
         $display("tb_hover_thrust_integral_controller: FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #40_000_000;
      $display("timeout waiting on transfers");
      $display("tb_hover_thrust_integral_controller: FAIL");
      $finish;
   end

endmodule
